>>> rtl/fern_pkg.sv
package fern_pkg;

   localparam int MAX_DIM_DEF   = 4096;
   localparam int FRAC_BITS_DEF = 24;

   localparam int PICK_W    = 7;
   localparam int PIXEL_W   = 12;
   localparam int COORD_W   = 32;
   localparam int DIM_CFG_W = 13;
   localparam int WARMUP_W  = 16;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_WARMUP_COUNT = 2'd2;

   localparam logic [DIM_CFG_W-1:0] WIDTH_RESET  = 13'd640;
   localparam logic [DIM_CFG_W-1:0] HEIGHT_RESET = 13'd480;
   localparam logic [WARMUP_W-1:0]  WARMUP_RESET = 16'd100;

   localparam int JOB_DEPTH = 2;
   localparam int PIX_DEPTH = 2;

   typedef enum logic [1:0] {
      MAP_STEM,
      MAP_LEFT,
      MAP_RIGHT,
      MAP_MAIN
   } map_type;

   typedef struct packed {
      map_type map;
      logic    plot;
   } job_type;

   typedef struct packed {
      logic [PIXEL_W-1:0] col;
      logic [PIXEL_W-1:0] row;
   } pixel_type;

   typedef struct packed {
      logic                   write_en;
      logic [CSR_INDEX_W-1:0] index;
      logic [CSR_DATA_W-1:0]  wdata;
   } csr_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] a;
      logic signed [COORD_W-1:0] b;
      logic signed [COORD_W-1:0] c;
      logic signed [COORD_W-1:0] d;
      logic signed [COORD_W-1:0] f;
   } coef_type;

   // hundredths to fixed point, rounded to nearest
   function automatic logic signed [COORD_W-1:0] to_fixed(int hundredths, int frac_bits);
      longint mag;
      longint q;
      mag = (hundredths < 0) ? -longint'(hundredths) : longint'(hundredths);
      q   = ((mag << frac_bits) + 64'sd50) / 64'sd100;
      return (hundredths < 0) ? COORD_W'(-q) : COORD_W'(q);
   endfunction

   function automatic coef_type map_coefs(map_type m, int frac_bits);
      coef_type c;
      case (m)
         MAP_STEM: begin
            c.a = to_fixed(0, frac_bits);
            c.b = to_fixed(0, frac_bits);
            c.c = to_fixed(0, frac_bits);
            c.d = to_fixed(16, frac_bits);
            c.f = to_fixed(0, frac_bits);
         end
         MAP_LEFT: begin
            c.a = to_fixed(20, frac_bits);
            c.b = to_fixed(-26, frac_bits);
            c.c = to_fixed(23, frac_bits);
            c.d = to_fixed(22, frac_bits);
            c.f = to_fixed(160, frac_bits);
         end
         MAP_RIGHT: begin
            c.a = to_fixed(-15, frac_bits);
            c.b = to_fixed(28, frac_bits);
            c.c = to_fixed(26, frac_bits);
            c.d = to_fixed(24, frac_bits);
            c.f = to_fixed(44, frac_bits);
         end
         default: begin
            c.a = to_fixed(85, frac_bits);
            c.b = to_fixed(4, frac_bits);
            c.c = to_fixed(-4, frac_bits);
            c.d = to_fixed(85, frac_bits);
            c.f = to_fixed(160, frac_bits);
         end
      endcase
      return c;
   endfunction

endpackage

>>> rtl/fern_queue.sv
module fern_queue #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> rtl/fern_front.sv
module fern_front (
   input  logic                                clock,
   input  logic                                reset,
   input  fern_pkg::csr_type                   csr,
   input  logic                                req_push,
   input  logic [fern_pkg::PICK_W-1:0]         req_random_pick,
   output logic                                req_full,
   input  logic                                job_full,
   output logic                                job_push,
   output fern_pkg::job_type                   job
);

   logic [fern_pkg::WARMUP_W-1:0] warmup_left_ff, warmup_left_in;
   fern_pkg::map_type             map_sel;

   assign req_full = job_full;
   assign job_push = req_push && !job_full;

   always_comb begin
      if (req_random_pick == '0) begin
         map_sel = fern_pkg::MAP_STEM;
      end else if (req_random_pick inside {[7'd1:7'd7]}) begin
         map_sel = fern_pkg::MAP_LEFT;
      end else if (req_random_pick inside {[7'd8:7'd14]}) begin
         map_sel = fern_pkg::MAP_RIGHT;
      end else begin
         map_sel = fern_pkg::MAP_MAIN;
      end
   end

   assign job.map  = map_sel;
   assign job.plot = (warmup_left_ff == '0);

   always_comb begin
      warmup_left_in = warmup_left_ff;
      if (csr.write_en && csr.index == fern_pkg::CSR_WARMUP_COUNT) begin
         warmup_left_in = csr.wdata;
      end else if (job_push && warmup_left_ff != '0) begin
         warmup_left_in = warmup_left_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         warmup_left_ff <= fern_pkg::WARMUP_RESET;
      end else begin
         warmup_left_ff <= warmup_left_in;
      end
   end

endmodule

>>> rtl/fern_back.sv
module fern_back #(
   parameter int MAX_DIM   = fern_pkg::MAX_DIM_DEF,
   parameter int FRAC_BITS = fern_pkg::FRAC_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  fern_pkg::csr_type   csr,
   input  logic                job_valid,
   input  fern_pkg::job_type   job,
   output logic                job_pop,
   input  logic                pix_full,
   output logic                pix_push,
   output fern_pkg::pixel_type pix
);

   localparam int CW     = fern_pkg::COORD_W;
   localparam int DIM_W  = $clog2(MAX_DIM + 1);
   localparam int OFS_W  = CW + 2;
   localparam int NUM_W  = OFS_W + DIM_W + 1;
   localparam int TW     = NUM_W - FRAC_BITS;
   localparam int QCW    = $clog2(6 * MAX_DIM);
   localparam int QRW    = $clog2(11 * MAX_DIM);
   localparam int SC     = QCW + 3;
   localparam int SR     = QRW + 4;
   localparam int MCW    = QCW + 2;
   localparam int MRW    = QRW + 2;
   localparam int DCW    = QCW + MCW;
   localparam int DRW    = QRW + MRW;

   localparam logic [63:0] MC = ((64'd1 << SC) + 64'd5) / 64'd6;
   localparam logic [63:0] MR = ((64'd1 << SR) + 64'd10) / 64'd11;

   localparam longint C_DEN = 64'sd6 <<< FRAC_BITS;
   localparam longint R_DEN = 64'sd11 <<< FRAC_BITS;

   localparam logic signed [OFS_W-1:0] X_OFS = OFS_W'(64'sd3 <<< FRAC_BITS);
   localparam logic signed [OFS_W-1:0] Y_OFS = OFS_W'(R_DEN);

   localparam logic signed [2*CW:0]   HALF   = (2*CW+1)'(64'sd1 <<< (FRAC_BITS - 1));
   localparam logic signed [2*CW+1:0] SAT_HI = (2*CW+2)'(64'sd2147483647);
   localparam logic signed [2*CW+1:0] SAT_LO = (2*CW+2)'(-64'sd2147483648);

   localparam fern_pkg::coef_type C_STEM  = fern_pkg::map_coefs(fern_pkg::MAP_STEM, FRAC_BITS);
   localparam fern_pkg::coef_type C_LEFT  = fern_pkg::map_coefs(fern_pkg::MAP_LEFT, FRAC_BITS);
   localparam fern_pkg::coef_type C_RIGHT = fern_pkg::map_coefs(fern_pkg::MAP_RIGHT, FRAC_BITS);
   localparam fern_pkg::coef_type C_MAIN  = fern_pkg::map_coefs(fern_pkg::MAP_MAIN, FRAC_BITS);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_X,
      ST_MUL_Y,
      ST_SUM,
      ST_ROUND,
      ST_SCALE,
      ST_BOUND,
      ST_DIVIDE,
      ST_EMIT
   } state_type;

   state_type                         state_ff, state_in;
   logic [fern_pkg::DIM_CFG_W-1:0]    width_ff, height_ff;
   fern_pkg::map_type                 map_ff;
   logic                              plot_ff;
   logic signed [CW-1:0]              x_ff, y_ff;
   logic signed [2*CW-1:0]            prod_a_ff, prod_b_ff, prod_c_ff, prod_d_ff;
   logic signed [2*CW:0]              sum_x_ff, sum_y_ff;
   logic signed [NUM_W-1:0]           num_c_ff, num_r_ff;
   logic [QCW-1:0]                    tq_c_ff;
   logic [QRW-1:0]                    tq_r_ff;
   logic                              inside_ff;
   fern_pkg::pixel_type               pix_ff;

   fern_pkg::coef_type                coef;
   logic [DIM_W-1:0]                  w_dim, h_dim;
   logic signed [2*CW:0]              rnd_x, rnd_y;
   logic signed [2*CW+1:0]            new_x, new_y;
   logic signed [CW-1:0]              x_in, y_in;
   logic signed [OFS_W-1:0]           x_ofs, y_ofs;
   logic signed [NUM_W-1:0]           num_c_in, num_r_in;
   logic [TW-1:0]                     t_c, t_r;
   logic                              inside_in;
   logic [DCW-1:0]                    div_c;
   logic [DRW-1:0]                    div_r;

   always_comb begin
      case (map_ff)
         fern_pkg::MAP_STEM:  coef = C_STEM;
         fern_pkg::MAP_LEFT:  coef = C_LEFT;
         fern_pkg::MAP_RIGHT: coef = C_RIGHT;
         default:             coef = C_MAIN;
      endcase
   end

   assign w_dim = (int'(width_ff) > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(width_ff);
   assign h_dim = (int'(height_ff) > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(height_ff);

   // round to nearest (ties up), add offset, saturate
   assign rnd_x = (sum_x_ff + HALF) >>> FRAC_BITS;
   assign rnd_y = (sum_y_ff + HALF) >>> FRAC_BITS;
   assign new_x = (2*CW+2)'(rnd_x);
   assign new_y = (2*CW+2)'(rnd_y) + (2*CW+2)'(coef.f);
   assign x_in  = (new_x > SAT_HI) ? CW'(SAT_HI) : (new_x < SAT_LO) ? CW'(SAT_LO) : CW'(new_x);
   assign y_in  = (new_y > SAT_HI) ? CW'(SAT_HI) : (new_y < SAT_LO) ? CW'(SAT_LO) : CW'(new_y);

   assign x_ofs    = OFS_W'(x_ff) + X_OFS;
   assign y_ofs    = Y_OFS - OFS_W'(y_ff);
   assign num_c_in = NUM_W'($signed({1'b0, w_dim})) * NUM_W'(x_ofs);
   assign num_r_in = NUM_W'($signed({1'b0, h_dim})) * NUM_W'(y_ofs);

   // small negative quotients truncate to zero
   assign t_c = num_c_ff[NUM_W-1] ? '0 : num_c_ff[NUM_W-1:FRAC_BITS];
   assign t_r = num_r_ff[NUM_W-1] ? '0 : num_r_ff[NUM_W-1:FRAC_BITS];
   assign inside_in = (64'(num_c_ff) > -C_DEN) && (64'(num_r_ff) > -R_DEN)
                   && (64'(t_c) < 64'(w_dim) * 64'd6)
                   && (64'(t_r) < 64'(h_dim) * 64'd11);

   assign div_c = DCW'(tq_c_ff) * DCW'(MC);
   assign div_r = DRW'(tq_r_ff) * DRW'(MR);

   assign job_pop  = (state_ff == ST_IDLE) && job_valid;
   assign pix_push = (state_ff == ST_EMIT) && inside_ff && !pix_full;
   assign pix      = pix_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (job_valid) state_in = ST_MUL_X;
         ST_MUL_X:  state_in = ST_MUL_Y;
         ST_MUL_Y:  state_in = ST_SUM;
         ST_SUM:    state_in = ST_ROUND;
         ST_ROUND:  state_in = plot_ff ? ST_SCALE : ST_IDLE;
         ST_SCALE:  state_in = ST_BOUND;
         ST_BOUND:  state_in = ST_DIVIDE;
         ST_DIVIDE: state_in = ST_EMIT;
         ST_EMIT:   if (!inside_ff || !pix_full) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         width_ff  <= fern_pkg::WIDTH_RESET;
         height_ff <= fern_pkg::HEIGHT_RESET;
         x_ff      <= '0;
         y_ff      <= '0;
      end else begin
         state_ff <= state_in;
         if (csr.write_en && csr.index == fern_pkg::CSR_IMAGE_WIDTH) begin
            width_ff <= csr.wdata[fern_pkg::DIM_CFG_W-1:0];
         end
         if (csr.write_en && csr.index == fern_pkg::CSR_IMAGE_HEIGHT) begin
            height_ff <= csr.wdata[fern_pkg::DIM_CFG_W-1:0];
         end
         if (state_ff == ST_ROUND) begin
            x_ff <= x_in;
            y_ff <= y_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            map_ff  <= job.map;
            plot_ff <= job.plot;
         end
         ST_MUL_X: begin
            prod_a_ff <= (2*CW)'($signed(coef.a)) * (2*CW)'(x_ff);
            prod_c_ff <= (2*CW)'($signed(coef.c)) * (2*CW)'(x_ff);
         end
         ST_MUL_Y: begin
            prod_b_ff <= (2*CW)'($signed(coef.b)) * (2*CW)'(y_ff);
            prod_d_ff <= (2*CW)'($signed(coef.d)) * (2*CW)'(y_ff);
         end
         ST_SUM: begin
            sum_x_ff <= (2*CW+1)'(prod_a_ff) + (2*CW+1)'(prod_b_ff);
            sum_y_ff <= (2*CW+1)'(prod_c_ff) + (2*CW+1)'(prod_d_ff);
         end
         ST_SCALE: begin
            num_c_ff <= num_c_in;
            num_r_ff <= num_r_in;
         end
         ST_BOUND: begin
            tq_c_ff   <= QCW'(t_c);
            tq_r_ff   <= QRW'(t_r);
            inside_ff <= inside_in;
         end
         ST_DIVIDE: begin
            pix_ff.col <= fern_pkg::PIXEL_W'(div_c >> SC);
            pix_ff.row <= fern_pkg::PIXEL_W'(div_r >> SR);
         end
         default: begin
         end
      endcase
   end

endmodule

>>> rtl/fern_ifs_point_generator.sv
// Barnsley fern point generator.
// Request side: a queue input. Drive req_random_pick (0..99) with req_push; the
// request is taken on a clock edge where req_full is low. Each request moves the
// kept point by one of the four fern maps.
// Result side: a queue output. While rsp_empty is low, rsp_pixel_col/rsp_pixel_row
// hold the oldest pixel; rsp_pop takes it. Points that fall outside the image,
// and the first warmup_count points, produce no pixel.
// Config: csr_write_en with csr_index/csr_wdata writes image_width (0),
// image_height (1) or warmup_count (2, also restarts the warm-up). Write only
// while the block is idle.
// The point sequencer takes one request at a time: MUL_X, MUL_Y, SUM and ROUND
// for the point recurrence, then SCALE, BOUND, DIVIDE and EMIT for the pixel
// mapping of a plotted request; a warm-up request returns to idle after ROUND.
// A two-entry queue on each side hides short bursts.
// Reset clears both queues, returns the point to the origin and restores the
// default registers (640 x 480, 100 warm-up points).
// A stalled receiver fills the result queue, then stalls the sequencer, then the
// request queue, after which req_full rises; nothing is dropped.
module fern_ifs_point_generator #(
   parameter int MAX_DIM   = fern_pkg::MAX_DIM_DEF,
   parameter int FRAC_BITS = fern_pkg::FRAC_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_push,
   output logic                               req_full,
   input  logic [fern_pkg::PICK_W-1:0]        req_random_pick,
   output logic                               rsp_empty,
   input  logic                               rsp_pop,
   output logic [fern_pkg::PIXEL_W-1:0]       rsp_pixel_col,
   output logic [fern_pkg::PIXEL_W-1:0]       rsp_pixel_row,
   input  logic                               csr_write_en,
   input  logic [fern_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [fern_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   fern_pkg::csr_type   csr;
   fern_pkg::job_type   job_in, job_out;
   fern_pkg::pixel_type pix_in, pix_out;
   logic                job_push, job_full, job_pop, job_empty;
   logic                pix_push, pix_full;

   assign csr.write_en = csr_write_en;
   assign csr.index    = csr_index;
   assign csr.wdata    = csr_wdata;

   fern_front u_front (
      .clock           (clock),
      .reset           (reset),
      .csr             (csr),
      .req_push        (req_push),
      .req_random_pick (req_random_pick),
      .req_full        (req_full),
      .job_full        (job_full),
      .job_push        (job_push),
      .job             (job_in)
   );

   fern_queue #(
      .WIDTH ($bits(fern_pkg::job_type)),
      .DEPTH (fern_pkg::JOB_DEPTH)
   ) u_job_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job_in),
      .full      (job_full),
      .pop       (job_pop),
      .pop_data  (job_out),
      .empty     (job_empty)
   );

   fern_back #(
      .MAX_DIM   (MAX_DIM),
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .csr       (csr),
      .job_valid (!job_empty),
      .job       (job_out),
      .job_pop   (job_pop),
      .pix_full  (pix_full),
      .pix_push  (pix_push),
      .pix       (pix_in)
   );

   fern_queue #(
      .WIDTH ($bits(fern_pkg::pixel_type)),
      .DEPTH (fern_pkg::PIX_DEPTH)
   ) u_pix_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (pix_push),
      .push_data (pix_in),
      .full      (pix_full),
      .pop       (rsp_pop),
      .pop_data  (pix_out),
      .empty     (rsp_empty)
   );

   assign rsp_pixel_col = pix_out.col;
   assign rsp_pixel_row = pix_out.row;

   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty && !req_full)
      else $error("queues not empty after reset");

   a_job_pop: assert property (@(posedge clock) disable iff (reset) job_pop |-> !job_empty)
      else $error("sequencer took a job from an empty queue");

   a_pix_push: assert property (@(posedge clock) disable iff (reset) pix_push |-> !pix_full)
      else $error("pixel pushed into a full result queue");

   a_job_held: assert property (@(posedge clock) disable iff (reset)
      (job_push && !job_pop) |=> !job_empty)
      else $error("accepted request lost before the sequencer");

endmodule

>>> sim/tb_fern_ifs_point_generator.sv
module tb_fern_ifs_point_generator;

   localparam int     FRAC           = fern_pkg::FRAC_BITS_DEF;
   localparam longint HALF_LSB       = longint'(1) <<< (FRAC - 1);
   localparam int     STEM_BELOW     = 1;
   localparam int     LEFT_BELOW     = 8;
   localparam int     RIGHT_BELOW    = 15;
   localparam int     SETTLE_CYCLES  = 64;
   localparam int     WATCHDOG_LIMIT = 4000;

   localparam logic [fern_pkg::CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;

   typedef struct {
      int a, b, c, d, f;
   } fern_coefs;

   // tracks the fern point and the pixels it should plot
   class fern_plot_tracker;
      fern_coefs                       coefs [4];
      int                              point_x;
      int                              point_y;
      logic [fern_pkg::WARMUP_W-1:0]   warmup_left;
      logic [fern_pkg::DIM_CFG_W-1:0]  image_width;
      logic [fern_pkg::DIM_CFG_W-1:0]  image_height;
      fern_pkg::pixel_type             due_pixels [$];
      int                              mismatches;

      function new();
         coefs[fern_pkg::MAP_STEM]  = '{to_q(0),   to_q(0),   to_q(0),   to_q(16), to_q(0)};
         coefs[fern_pkg::MAP_LEFT]  = '{to_q(20),  to_q(-26), to_q(23),  to_q(22), to_q(160)};
         coefs[fern_pkg::MAP_RIGHT] = '{to_q(-15), to_q(28),  to_q(26),  to_q(24), to_q(44)};
         coefs[fern_pkg::MAP_MAIN]  = '{to_q(85),  to_q(4),   to_q(-4),  to_q(85), to_q(160)};
         point_x      = 0;
         point_y      = 0;
         image_width  = fern_pkg::WIDTH_RESET;
         image_height = fern_pkg::HEIGHT_RESET;
         warmup_left  = fern_pkg::WARMUP_RESET;
         mismatches   = 0;
      endfunction

      function int to_q(int hundredths);
         longint mag, q;
         mag = (hundredths < 0) ? -hundredths : hundredths;
         q   = ((mag <<< FRAC) + 50) / 100;
         return (hundredths < 0) ? int'(-q) : int'(q);
      endfunction

      function int clip32(longint v);
         if (v > longint'(32'sh7FFF_FFFF)) return 32'sh7FFF_FFFF;
         if (v < -longint'(32'sh7FFF_FFFF) - 1) return 32'sh8000_0000;
         return int'(v);
      endfunction

      function void set_register(logic [fern_pkg::CSR_INDEX_W-1:0] index,
                                 logic [fern_pkg::CSR_DATA_W-1:0] value);
         case (index)
            fern_pkg::CSR_IMAGE_WIDTH:  image_width  = value[fern_pkg::DIM_CFG_W-1:0];
            fern_pkg::CSR_IMAGE_HEIGHT: image_height = value[fern_pkg::DIM_CFG_W-1:0];
            fern_pkg::CSR_WARMUP_COUNT: warmup_left  = value[fern_pkg::WARMUP_W-1:0];
            default: ;
         endcase
      endfunction

      function void note_pick(logic [fern_pkg::PICK_W-1:0] pick);
         fern_pkg::map_type   m;
         fern_coefs           k;
         longint              sum_x, sum_y, w, h, col, row;
         fern_pkg::pixel_type px;
         if (pick < STEM_BELOW) m = fern_pkg::MAP_STEM;
         else if (pick < LEFT_BELOW) m = fern_pkg::MAP_LEFT;
         else if (pick < RIGHT_BELOW) m = fern_pkg::MAP_RIGHT;
         else m = fern_pkg::MAP_MAIN;
         k = coefs[m];
         sum_x   = longint'(k.a) * point_x + longint'(k.b) * point_y;
         sum_y   = longint'(k.c) * point_x + longint'(k.d) * point_y;
         point_x = clip32((sum_x + HALF_LSB) >>> FRAC);
         point_y = clip32(((sum_y + HALF_LSB) >>> FRAC) + k.f);
         if (warmup_left != 0) begin
            warmup_left = warmup_left - 1'b1;
            return;
         end
         w   = (image_width > fern_pkg::MAX_DIM_DEF) ? fern_pkg::MAX_DIM_DEF : image_width;
         h   = (image_height > fern_pkg::MAX_DIM_DEF) ? fern_pkg::MAX_DIM_DEF : image_height;
         col = (w * (longint'(point_x) + (longint'(3) <<< FRAC))) / (longint'(6) <<< FRAC);
         row = (h * ((longint'(11) <<< FRAC) - point_y)) / (longint'(11) <<< FRAC);
         if (col < 0 || col >= w || row < 0 || row >= h) return;
         px.col = col[fern_pkg::PIXEL_W-1:0];
         px.row = row[fern_pkg::PIXEL_W-1:0];
         due_pixels.push_back(px);
      endfunction

      function void report_mismatch(string text);
         mismatches++;
         if (mismatches <= 10) $display("%s", text);
      endfunction

      function void check_pixel(logic [fern_pkg::PIXEL_W-1:0] col,
                                logic [fern_pkg::PIXEL_W-1:0] row);
         fern_pkg::pixel_type want;
         if (due_pixels.size() == 0) begin
            report_mismatch($sformatf("unexpected pixel col %0d row %0d", col, row));
            return;
         end
         want = due_pixels.pop_front();
         if (col !== want.col)
            report_mismatch($sformatf("pixel col mismatch: expected %0d, got %0d (row %0d)",
                                      want.col, col, want.row));
         if (row !== want.row)
            report_mismatch($sformatf("pixel row mismatch: expected %0d, got %0d (col %0d)",
                                      want.row, row, want.col));
      endfunction

      function int pending();
         return due_pixels.size();
      endfunction
   endclass

   logic                             clock           = 1'b0;
   logic                             reset           = 1'b1;
   logic                             req_push        = 1'b0;
   logic                             req_full;
   logic [fern_pkg::PICK_W-1:0]      req_random_pick = '0;
   logic                             rsp_empty;
   logic                             rsp_pop         = 1'b0;
   logic [fern_pkg::PIXEL_W-1:0]     rsp_pixel_col;
   logic [fern_pkg::PIXEL_W-1:0]     rsp_pixel_row;
   logic                             csr_write_en    = 1'b0;
   logic [fern_pkg::CSR_INDEX_W-1:0] csr_index       = '0;
   logic [fern_pkg::CSR_DATA_W-1:0]  csr_wdata       = '0;

   fern_plot_tracker tracker;
   int               hold_left = 0;
   logic [9:0]       rx_cycle  = '0;

   fern_ifs_point_generator u_top (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_random_pick (req_random_pick),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_pixel_col   (rsp_pixel_col),
      .rsp_pixel_row   (rsp_pixel_row),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #4 clock = ~clock;

   // receiver: random stalls, none of them started while rx_cycle[9:8] is 3
   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) tracker.check_pixel(rsp_pixel_col, rsp_pixel_row);
      if (hold_left != 0) begin
         rsp_pop   <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (rx_cycle[9:8] != 2'd3 && $urandom_range(0, 7) == 0) begin
         rsp_pop   <= 1'b0;
         hold_left <= $urandom_range(0, 39);
      end else begin
         rsp_pop <= 1'b1;
      end
      rx_cycle <= rx_cycle + 1'b1;
   end

   initial begin
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_push && !req_full) || (rsp_pop && !rsp_empty)) quiet = 0;
         else quiet++;
      end
      $display("== FAIL ==");
      $finish;
   end

   task automatic push_pick(input logic [fern_pkg::PICK_W-1:0] pick);
      req_push        <= 1'b1;
      req_random_pick <= pick;
      @(posedge clock);
      while (req_full) @(posedge clock);
      tracker.note_pick(pick);
   endtask

   task automatic hold_requests(input int cycles);
      req_push <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic await_results();
      req_push <= 1'b0;
      do begin
         @(posedge clock);
      end while (tracker.pending() != 0);
   endtask

   // requests that plot nothing may still be in flight
   task automatic drain();
      await_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [fern_pkg::CSR_INDEX_W-1:0] index,
                            input logic [fern_pkg::CSR_DATA_W-1:0] value);
      csr_write_en <= 1'b1;
      csr_index    <= index;
      csr_wdata    <= value;
      @(posedge clock);
      tracker.set_register(index, value);
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [fern_pkg::PICK_W-1:0] random_pick();
      if ($urandom_range(0, 15) == 0) return fern_pkg::PICK_W'($urandom_range(100, 127));
      return fern_pkg::PICK_W'($urandom_range(0, 99));
   endfunction

   function automatic logic [fern_pkg::CSR_DATA_W-1:0] random_dim();
      case ($urandom_range(0, 5))
         0:       return 16'd1;
         1:       return 16'd4096;
         2:       return 16'hFFFF;
         3:       return fern_pkg::CSR_DATA_W'($urandom_range(2, 64));
         default: return fern_pkg::CSR_DATA_W'($urandom_range(1, 4096));
      endcase
   endfunction

   task automatic feed_random(input int count);
      int sent, burst;
      sent = 0;
      while (sent < count) begin
         burst = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 50) : $urandom_range(1, 10);
         for (int i = 0; i < burst && sent < count; i++) begin
            push_pick(random_pick());
            sent++;
         end
         if ($urandom_range(0, 2) != 0) hold_requests($urandom_range(1, 16));
      end
   endtask

   initial begin
      tracker = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // default warm-up swallows the first request; the stem map keeps the origin
      push_pick(0);
      drain();
      csr_write(fern_pkg::CSR_WARMUP_COUNT, 16'd0);
      // origin sits on the bottom edge, just outside the image
      push_pick(0);
      push_pick(1);
      push_pick(7);
      push_pick(8);
      push_pick(14);
      push_pick(15);
      push_pick(99);
      push_pick(100);
      push_pick(127);
      push_pick(50);
      drain();

      csr_write(fern_pkg::CSR_IMAGE_WIDTH, 16'd0);
      push_pick(20);
      push_pick(3);
      drain();
      csr_write(fern_pkg::CSR_IMAGE_WIDTH, 16'hFFFF);
      csr_write(fern_pkg::CSR_IMAGE_HEIGHT, 16'd8191);
      push_pick(60);
      push_pick(10);
      drain();
      csr_write(fern_pkg::CSR_IMAGE_WIDTH, 16'd1);
      csr_write(fern_pkg::CSR_IMAGE_HEIGHT, 16'd1);
      push_pick(90);
      push_pick(5);
      drain();
      csr_write(fern_pkg::CSR_IMAGE_WIDTH, 16'd4096);
      csr_write(fern_pkg::CSR_IMAGE_HEIGHT, 16'd4096);
      csr_write(fern_pkg::CSR_WARMUP_COUNT, 16'd2);
      push_pick(33);
      push_pick(0);
      push_pick(12);
      push_pick(77);
      drain();
      csr_write(CSR_UNUSED, 16'hFFFF);
      csr_write(fern_pkg::CSR_WARMUP_COUNT, 16'hFFFF);
      push_pick(127);
      push_pick(40);
      drain();

      for (int phase = 0; phase < 9; phase++) begin
         csr_write(fern_pkg::CSR_IMAGE_WIDTH, random_dim());
         csr_write(fern_pkg::CSR_IMAGE_HEIGHT, random_dim());
         csr_write(fern_pkg::CSR_WARMUP_COUNT, ($urandom_range(0, 3) == 0) ? 16'd0 :
                   fern_pkg::CSR_DATA_W'($urandom_range(1, 40)));
         feed_random(30);
         if (phase == 0 || $urandom_range(0, 1) == 1) await_results();
         feed_random(30);
         drain();
      end

      if (tracker.pending() != 0) $display("%0d pixels never arrived", tracker.pending());
      if (tracker.mismatches == 0 && tracker.pending() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
